// ===== hw/rtl/dbrq_pkg.sv =====
`default_nettype none

package dbrq_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 8;

    // Retransmit status codes; values below STATUS_NO_RETX are a countdown
    localparam logic [7:0] STATUS_NO_RETX = 8'h80;
    localparam logic [7:0] STATUS_PENDING = 8'hff;
    localparam logic [7:0] STATUS_ACKED   = 8'hfe;

    localparam logic [7:0] IDLE_STATE_RESET   = 8'h00;
    localparam logic [3:0] BUTTON_COUNT_RESET = 4'd8;
    localparam logic [6:0] RETX_PERIOD_RESET  = 7'd0;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_BUTTON_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RETX_PERIOD  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_IDLE_STATE   = 2'd2;

    typedef enum logic [0:0] {
        OP_SAMPLE = 1'b0,
        OP_ACK    = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_FETCH,
        ST_HOLD
    } state_t;

    typedef struct packed {
        logic in_ready;
        logic start_send;
        logic fetch;
        logic advance;
    } cmd_t;

    typedef struct packed {
        logic sample_fire;
        logic send_go;
        logic out_done;
        logic out_last;
    } sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dbrq_ctrl.sv =====
`default_nettype none

module dbrq_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire dbrq_pkg::sts_t sts,
    output dbrq_pkg::cmd_t     cmd
);

    dbrq_pkg::state_t state_reg;
    dbrq_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dbrq_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dbrq_pkg::ST_IDLE:
            begin
                if (sts.sample_fire)
                begin
                    state_next = dbrq_pkg::ST_DECIDE;
                end
            end
            dbrq_pkg::ST_DECIDE:
            begin
                state_next = sts.send_go ? dbrq_pkg::ST_FETCH : dbrq_pkg::ST_IDLE;
            end
            dbrq_pkg::ST_FETCH:
            begin
                state_next = dbrq_pkg::ST_HOLD;
            end
            dbrq_pkg::ST_HOLD:
            begin
                if (sts.out_done)
                begin
                    state_next = sts.out_last ? dbrq_pkg::ST_IDLE : dbrq_pkg::ST_FETCH;
                end
            end
            default:
            begin
                state_next = dbrq_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            dbrq_pkg::ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
            end
            dbrq_pkg::ST_DECIDE:
            begin
                cmd.start_send = sts.send_go;
            end
            dbrq_pkg::ST_FETCH:
            begin
                cmd.fetch = 1'b1;
            end
            dbrq_pkg::ST_HOLD:
            begin
                cmd.advance = sts.out_done;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/dbrq_datapath.sv =====
`default_nettype none

module dbrq_datapath #(
    parameter int QUEUE_DEPTH = dbrq_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    input  wire dbrq_pkg::op_t                    in_op,
    input  wire logic [7:0]                       in_pins,
    input  wire logic [7:0]                       in_amount,
    input  wire logic                             out_ready,
    input  wire logic                             cfg_we,
    input  wire logic [dbrq_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [dbrq_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire dbrq_pkg::cmd_t                   cmd,
    output dbrq_pkg::sts_t                        sts,
    output logic                                  out_valid,
    output logic [7:0]                            out_ack_total,
    output logic [7:0]                            out_report,
    output logic                                  out_last
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = PTR_W + 1;

    logic [7:0]       queue_mem [QUEUE_DEPTH];

    logic [3:0]       button_count_reg;
    logic [6:0]       period_reg;
    logic [7:0]       debounced_reg;
    logic [7:0]       prev_sample_reg;
    logic [PTR_W-1:0] head_reg;
    logic [CNT_W-1:0] count_reg;
    logic [7:0]       ack_total_reg;
    logic [7:0]       status_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] send_idx_reg;
    logic             out_valid_reg;
    logic [7:0]       out_ack_total_reg;
    logic [7:0]       out_report_reg;
    logic             out_last_reg;

    logic             fire;
    logic             sample_fire;
    logic             ack_fire;
    logic [7:0]       pin_mask;
    logic [7:0]       pins_masked;
    logic [7:0]       diff;
    logic [7:0]       stable;
    logic             change;
    logic [7:0]       debounced_upd;
    logic             can_queue;
    logic             push;
    logic [SUM_W-1:0] tail_sum;
    logic [SUM_W-1:0] tail_wrap;
    logic [PTR_W-1:0] tail_ptr;
    logic [7:0]       status_pushed;
    logic [7:0]       status_tick;
    logic             ack_all;
    logic [SUM_W-1:0] head_sum;
    logic [SUM_W-1:0] head_wrap;
    logic [SUM_W-1:0] rd_sum;
    logic [SUM_W-1:0] rd_wrap;

    assign fire        = in_valid && cmd.in_ready;
    assign sample_fire = fire && (in_op == dbrq_pkg::OP_SAMPLE);
    assign ack_fire    = fire && (in_op == dbrq_pkg::OP_ACK);

    always_comb
    begin
        if (button_count_reg >= 4'd8)
        begin
            pin_mask = 8'hff;
        end
        else
        begin
            pin_mask = 8'((9'd1 << button_count_reg) - 9'd1);
        end
    end

    // A bit follows its pin only where the last two samples agree
    assign pins_masked   = in_pins & pin_mask;
    assign diff          = pins_masked ^ debounced_reg;
    assign stable        = ~(pins_masked ^ prev_sample_reg);
    assign change        = |(diff & stable);
    assign debounced_upd = (debounced_reg & ~stable) | (pins_masked & stable);

    assign can_queue = count_reg < CNT_W'(QUEUE_DEPTH);
    assign push      = sample_fire && change && can_queue;

    assign tail_sum  = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign tail_wrap = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ? tail_sum - SUM_W'(QUEUE_DEPTH)
                                                         : tail_sum;
    assign tail_ptr  = tail_wrap[PTR_W-1:0];

    assign status_pushed = push ? dbrq_pkg::STATUS_PENDING : status_reg;
    assign status_tick   = ((status_pushed & dbrq_pkg::STATUS_NO_RETX) != 8'h00)
                           ? status_pushed : status_pushed - 8'd1;

    assign ack_all   = in_amount >= 8'(count_reg);
    assign head_sum  = SUM_W'(head_reg) + SUM_W'(in_amount[PTR_W-1:0]);
    assign head_wrap = (head_sum >= SUM_W'(QUEUE_DEPTH)) ? head_sum - SUM_W'(QUEUE_DEPTH)
                                                         : head_sum;

    assign rd_sum  = SUM_W'(rd_ptr_reg) + SUM_W'(1);
    assign rd_wrap = (rd_sum >= SUM_W'(QUEUE_DEPTH)) ? rd_sum - SUM_W'(QUEUE_DEPTH) : rd_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            button_count_reg <= dbrq_pkg::BUTTON_COUNT_RESET;
            period_reg       <= dbrq_pkg::RETX_PERIOD_RESET;
            debounced_reg    <= dbrq_pkg::IDLE_STATE_RESET;
            prev_sample_reg  <= dbrq_pkg::IDLE_STATE_RESET;
            head_reg         <= '0;
            count_reg        <= '0;
            ack_total_reg    <= 8'h00;
            status_reg       <= dbrq_pkg::STATUS_ACKED;
            rd_ptr_reg       <= '0;
            send_idx_reg     <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    dbrq_pkg::REG_BUTTON_COUNT:
                    begin
                        button_count_reg <= cfg_data[3:0];
                    end
                    dbrq_pkg::REG_RETX_PERIOD:
                    begin
                        period_reg <= cfg_data[6:0];
                    end
                    dbrq_pkg::REG_IDLE_STATE:
                    begin
                        debounced_reg   <= cfg_data;
                        prev_sample_reg <= cfg_data;
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if (sample_fire)
            begin
                if (change)
                begin
                    debounced_reg <= debounced_upd;
                end
                prev_sample_reg <= pins_masked;
                if (push)
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
                status_reg <= status_tick;
            end
            else if (ack_fire)
            begin
                ack_total_reg <= ack_total_reg + in_amount;
                if (ack_all)
                begin
                    count_reg  <= '0;
                    status_reg <= dbrq_pkg::STATUS_ACKED;
                end
                else
                begin
                    // Drop acknowledged entries from the head
                    count_reg <= count_reg - in_amount[CNT_W-1:0];
                    head_reg  <= head_wrap[PTR_W-1:0];
                end
            end

            if (cmd.start_send)
            begin
                status_reg   <= 8'(period_reg);
                rd_ptr_reg   <= head_reg;
                send_idx_reg <= '0;
            end
            else if (cmd.advance)
            begin
                rd_ptr_reg   <= rd_wrap[PTR_W-1:0];
                send_idx_reg <= send_idx_reg + CNT_W'(1);
            end

            if (cmd.fetch)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[tail_ptr] <= debounced_upd;
        end
        if (cmd.fetch)
        begin
            out_report_reg    <= queue_mem[rd_ptr_reg];
            out_ack_total_reg <= ack_total_reg;
            out_last_reg      <= (send_idx_reg == count_reg - CNT_W'(1));
        end
    end

    assign sts.sample_fire = sample_fire;
    assign sts.send_go     = (status_reg == dbrq_pkg::STATUS_PENDING) && (count_reg != '0);
    assign sts.out_done    = out_valid_reg && out_ready;
    assign sts.out_last    = out_last_reg;

    assign out_valid     = out_valid_reg;
    assign out_ack_total = out_ack_total_reg;
    assign out_report    = out_report_reg;
    assign out_last      = out_last_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/button_debounce_report_queue.sv =====
// An acknowledgement keeps the block idle; a sample tick passes through a decision state that
// either returns to idle or starts a send. A send fetches one report at a time and holds it
// until the output takes it before fetching the next (single read port of the queue memory
// feeding a one-deep output register); input is taken again after the final transfer.
// Reset: asynchronous, active low; clears control, counters and configuration, queue
// contents stay undefined until written.
`default_nettype none

module button_debounce_report_queue #(
    parameter int QUEUE_DEPTH = dbrq_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire logic [15:0]                      s_axis_tdata,  // pin_levels, ack_amount
    input  wire logic                             s_axis_tuser,  // op
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    output logic [15:0]                           m_axis_tdata,  // ack_total, report_state
    output logic                                  m_axis_tlast,
    input  wire logic                             cfg_we,
    input  wire logic [dbrq_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [dbrq_pkg::CFG_DATA_W-1:0]  cfg_data
);

    dbrq_pkg::cmd_t cmd;
    dbrq_pkg::sts_t sts;
    dbrq_pkg::op_t  in_op;
    logic [7:0]     out_ack_total;
    logic [7:0]     out_report;

    assign in_op = dbrq_pkg::op_t'(s_axis_tuser);

    dbrq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    dbrq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_axis_tvalid),
        .in_op         (in_op),
        .in_pins       (s_axis_tdata[7:0]),
        .in_amount     (s_axis_tdata[15:8]),
        .out_ready     (m_axis_tready),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .sts           (sts),
        .out_valid     (m_axis_tvalid),
        .out_ack_total (out_ack_total),
        .out_report    (out_report),
        .out_last      (m_axis_tlast)
    );

    assign s_axis_tready = cmd.in_ready;
    assign m_axis_tdata  = {out_report, out_ack_total};

endmodule

`default_nettype wire

// ===== hw/rtl/dbrq_checker.sv =====
`default_nettype none

module dbrq_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             s_axis_tvalid,
    input wire logic                             s_axis_tready,
    input wire logic                             s_axis_tuser,
    input wire logic                             m_axis_tvalid,
    input wire logic                             m_axis_tready,
    input wire logic [15:0]                      m_axis_tdata,
    input wire logic                             m_axis_tlast
);

    // Input is taken only while no report is on offer
    assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while a report is offered");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready)
        |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("stalled report changed");

    // An accepted sample tick is followed by a decision cycle with nothing on either side
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser == dbrq_pkg::OP_SAMPLE))
        |=> (!m_axis_tvalid && !s_axis_tready))
        else $error("no decision cycle after an accepted sample tick");

    // The final report of a run returns the block to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> (!m_axis_tvalid && s_axis_tready))
        else $error("block not idle after final report");

endmodule

bind button_debounce_report_queue dbrq_checker u_dbrq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ===== verif/tb_button_debounce_report_queue.sv =====
`timescale 1ns / 1ps

module tb_button_debounce_report_queue;

    import dbrq_pkg::*;

    localparam int                     QDEPTH        = QUEUE_DEPTH_DEFAULT;
    localparam int                     CYCLE_LIMIT   = 300000;
    localparam int                     SETTLE_CYCLES = 12;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED    = 2'd3;

    typedef struct {
        op_t         op;
        logic [7:0]  pins;
        logic [7:0]  amount;
        int unsigned gap;
    } button_cmd_t;

    typedef struct packed {
        logic [7:0] total;
        logic [7:0] state;
        logic       last;
    } report_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [15:0]            s_axis_tdata;   // pin_levels, ack_amount
    logic                   s_axis_tuser;   // op
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [15:0]            m_axis_tdata;   // ack_total, report_state
    logic                   m_axis_tlast;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Stimulus and expected report queues
    button_cmd_t cmd_fifo[$];
    report_t     awaited_reports[$];
    int          pushed_count;
    int          taken_count;
    int          fail_count;
    bit          gaps_on;

    // Predicted block state
    logic [3:0]  cfg_buttons;
    logic [6:0]  cfg_period;
    logic [7:0]  deb_state;
    logic [7:0]  last_sample;
    logic [7:0]  rep_queue[QDEPTH];
    int          rep_count;
    logic [7:0]  ack_sum;
    logic [7:0]  retx_status;

    button_debounce_report_queue i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Regression FAIL");
        $finish;
    end

    task automatic flag_mismatch(input string msg);
        fail_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Debounce one tick or apply one acknowledgement; queue the reports it sends
    task automatic compute_reports(input button_cmd_t c);
        int         i;
        int         n;
        int         keep;
        logic [7:0] mask;
        logic [7:0] sample;
        logic [7:0] diff;
        logic [7:0] stable;
        if (c.op == OP_ACK)
        begin
            ack_sum = ack_sum + c.amount;
            if (int'(c.amount) >= rep_count)
            begin
                rep_count   = 0;
                retx_status = STATUS_ACKED;
            end
            else
            begin
                keep = rep_count - int'(c.amount);
                for (i = 0; i < keep; i++)
                    rep_queue[i] = rep_queue[i + int'(c.amount)];
                rep_count = keep;
            end
        end
        else
        begin
            n      = (cfg_buttons > 4'd8) ? 8 : int'(cfg_buttons);
            mask   = 8'((1 << n) - 1);
            sample = c.pins & mask;
            diff   = sample ^ deb_state;
            stable = ~(sample ^ last_sample);
            if ((diff & stable) != 8'h00)
            begin
                deb_state = (deb_state & ~stable) | (sample & stable);
                // a full queue still takes the new state, it just is not reported
                if (rep_count < QDEPTH)
                begin
                    rep_queue[rep_count] = deb_state;
                    rep_count++;
                    retx_status = STATUS_PENDING;
                end
            end
            last_sample = sample;
            if ((retx_status & STATUS_NO_RETX) == 8'h00)
                retx_status = retx_status - 8'd1;
            if (retx_status == STATUS_PENDING && rep_count > 0)
            begin
                retx_status = {1'b0, cfg_period};
                for (i = 0; i < rep_count; i++)
                    awaited_reports.push_back('{total: ack_sum, state: rep_queue[i],
                                                last: (i == rep_count - 1)});
            end
        end
    endtask

    task automatic send_item(input op_t op, input logic [7:0] pins, input logic [7:0] amount);
        button_cmd_t c;
        c.op     = op;
        c.pins   = pins;
        c.amount = amount;
        c.gap    = gaps_on ? $urandom_range(0, 6) : 0;
        cmd_fifo.push_back(c);
        pushed_count++;
    endtask

    // Hold until every queued command is taken and every report has arrived
    task automatic settle_idle();
        while (pushed_count != taken_count || awaited_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Only called while the block is idle and on a clock edge
    task automatic set_config(input logic [7:0] buttons, input logic [7:0] period,
                              input logic [7:0] idle);
        cfg_we    <= 1'b1;
        cfg_index <= REG_BUTTON_COUNT;
        cfg_data  <= buttons;
        @(posedge clk);
        cfg_index <= REG_RETX_PERIOD;
        cfg_data  <= period;
        @(posedge clk);
        cfg_index <= REG_IDLE_STATE;
        cfg_data  <= idle;
        @(posedge clk);
        // an unmapped index must leave everything untouched
        cfg_index <= REG_UNUSED;
        cfg_data  <= 8'($urandom);
        @(posedge clk);
        cfg_we <= 1'b0;
        cfg_buttons = buttons[3:0];
        cfg_period  = period[6:0];
        deb_state   = idle;
        last_sample = idle;
    endtask

    // Reset register values: resend on every tick after a send
    task automatic test_reset_defaults();
        send_item(OP_SAMPLE, 8'hff, 8'h00);
        send_item(OP_SAMPLE, 8'hff, 8'hff);
        send_item(OP_SAMPLE, 8'h00, 8'h00);
        send_item(OP_SAMPLE, 8'h00, 8'h00);
        send_item(OP_ACK,    8'hff, 8'd1);
        send_item(OP_SAMPLE, 8'h00, 8'h00);
        send_item(OP_ACK,    8'h00, 8'hff);
        send_item(OP_ACK,    8'h00, 8'h00);
        send_item(OP_SAMPLE, 8'h5a, 8'h00);
        settle_idle();
    endtask

    // A rolling bit pattern gives one new state per tick until the queue overflows
    task automatic test_queue_overflow();
        logic [7:0] pattern;
        set_config(8'd8, 8'd127, 8'h00);
        pattern = 8'h00;
        for (int k = 0; k < 10; k++)
        begin
            pattern = pattern ^ 8'(1 << (k % 8));
            send_item(OP_SAMPLE, pattern, 8'h00);
        end
        send_item(OP_ACK, 8'h00, 8'd3);
        send_item(OP_SAMPLE, pattern ^ 8'h04, 8'h00);
        settle_idle();
    endtask

    // No pins sampled, idle state all ones, retransmit countdown period of one
    task automatic test_pin_mask_and_idle_load();
        set_config(8'd0, 8'd1, 8'hff);
        send_item(OP_SAMPLE, 8'haa, 8'h00);
        send_item(OP_SAMPLE, 8'haa, 8'h00);
        send_item(OP_SAMPLE, 8'h00, 8'h00);
        send_item(OP_SAMPLE, 8'h00, 8'h00);
        settle_idle();
    endtask

    task automatic test_random_traffic(input logic [7:0] buttons, input logic [7:0] period,
                                       input logic [7:0] idle, input int count);
        int         sent;
        int         pick;
        int         reps;
        bit         paused;
        logic [7:0] pattern;
        set_config(buttons, period, idle);
        sent   = 0;
        paused = 1'b0;
        while (sent < count)
        begin
            if ($urandom_range(0, 11) == 0)
                gaps_on = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 99);
            if (pick < 50)
            begin
                // a press or release held long enough to pass the debounce
                pattern = 8'($urandom);
                reps    = $urandom_range(2, 3);
                repeat (reps) send_item(OP_SAMPLE, pattern, 8'($urandom));
                sent += reps;
            end
            else if (pick < 62)
            begin
                send_item(OP_SAMPLE, 8'($urandom), 8'($urandom));
                sent++;
            end
            else if (pick < 82)
            begin
                send_item(OP_ACK, 8'($urandom), 8'($urandom_range(0, 4)));
                sent++;
            end
            else if (pick < 92)
            begin
                send_item(OP_ACK, 8'($urandom), 8'($urandom_range(0, 255)));
                sent++;
            end
            else
            begin
                pattern = 8'($urandom);
                for (int k = 0; k < 9; k++)
                begin
                    pattern = pattern ^ 8'(1 << (k % 8));
                    send_item(OP_SAMPLE, pattern, 8'($urandom));
                end
                sent += 9;
            end
            if (!paused && sent >= count / 2)
            begin
                settle_idle();
                paused = 1'b1;
            end
        end
        settle_idle();
    endtask

    // Slave side: one command per transfer, gap drawn when it was queued
    initial
    begin : feed_driver
        button_cmd_t c;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_SAMPLE;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            if (cmd_fifo.size() == 0)
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                c = cmd_fifo.pop_front();
                if (c.gap != 0)
                begin
                    s_axis_tvalid <= 1'b0;
                    repeat (c.gap) @(posedge clk);
                end
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {c.amount, c.pins};
                s_axis_tuser  <= c.op;
                do @(posedge clk); while (s_axis_tready !== 1'b1);
                compute_reports(c);
                taken_count++;
            end
        end
    end

    // Master side: random stall after each transfer while gaps are on, compare against the oldest expectation
    initial
    begin : report_checker
        int      stall;
        report_t exp_rep;
        stall = 0;
        m_axis_tready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        m_axis_tready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid === 1'b1 && m_axis_tready)
            begin
                if (awaited_reports.size() == 0)
                    flag_mismatch($sformatf("unexpected report tdata=%h tlast=%b",
                                            m_axis_tdata, m_axis_tlast));
                else
                begin
                    exp_rep = awaited_reports.pop_front();
                    if (m_axis_tdata[7:0] !== exp_rep.total)
                        flag_mismatch($sformatf("ack_total %h, expected %h",
                                                m_axis_tdata[7:0], exp_rep.total));
                    if (m_axis_tdata[15:8] !== exp_rep.state)
                        flag_mismatch($sformatf("report_state %h, expected %h",
                                                m_axis_tdata[15:8], exp_rep.state));
                    if (m_axis_tlast !== exp_rep.last)
                        flag_mismatch($sformatf("tlast %b, expected %b",
                                                m_axis_tlast, exp_rep.last));
                end
                stall = gaps_on ? $urandom_range(0, 6) : 0;
            end
            else if (stall > 0)
                stall--;
            m_axis_tready <= (stall == 0);
        end
    end

    initial
    begin
        fail_count   = 0;
        pushed_count = 0;
        taken_count  = 0;
        gaps_on      = 1'b1;
        cfg_buttons  = BUTTON_COUNT_RESET;
        cfg_period   = RETX_PERIOD_RESET;
        deb_state    = IDLE_STATE_RESET;
        last_sample  = IDLE_STATE_RESET;
        rep_count    = 0;
        ack_sum      = 8'h00;
        retx_status  = STATUS_ACKED;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_BUTTON_COUNT;
        cfg_data  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_queue_overflow();
        test_pin_mask_and_idle_load();
        test_random_traffic(8'd8, 8'd0, 8'h00, 50);
        test_random_traffic(8'd3, 8'd2, 8'ha5, 50);
        test_random_traffic(8'hff, 8'hff, 8'hff, 50);
        test_random_traffic(8'h00, 8'd1, 8'($urandom), 40);
        test_random_traffic(8'($urandom), {1'($urandom_range(0, 1)), 7'($urandom_range(0, 5))},
                            8'($urandom), 60);

        settle_idle();
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
